### hw/rtl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// Used by pps_slot_mem, pps_scan_unit and preemptive_priority_scheduler.
`default_nettype none

package pps_pkg;

	// Fixed field widths of the stream beats and config register
	localparam int CMD_W = 2;
	localparam int SLOT_W = 4;
	localparam int PID_W = 8;
	localparam int VAL_W = 16;
	localparam int CNT_W = 5;

	// Bus widths: data packed from bit 0 up, tdata padded to whole bytes
	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 72;
	localparam int M_TUSER_W = 2;

	// Parameter defaults
	localparam int MAX_SLOTS_DEF = 16;
	localparam int TIME_W_DEF = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	// Slot table control from the sequencer
	typedef struct packed {
		logic rd_en;
		logic load_we;
		logic rem_we;
		logic clear_all;
	} mem_ctrl_t;

	// Winner of a scan pass
	typedef struct packed {
		logic found;
		logic [PID_W-1:0] pid;
		logic [VAL_W-1:0] arrival;
		logic [VAL_W-1:0] burst;
		logic [VAL_W-1:0] rem;
	} scan_best_t;

endpackage

`default_nettype wire

### hw/rtl/pps_slot_mem.sv
// Process slot table: pid, arrival, burst, priority and remaining work.
// One write port, one registered read port; depends on pps_pkg.
`default_nettype none

module pps_slot_mem import pps_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	localparam int SW = $clog2(MAX_SLOTS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mem_ctrl_t        ctrl,
	input  wire logic [SW-1:0]    wr_addr,
	input  wire logic [PID_W-1:0] wr_pid,
	input  wire logic [VAL_W-1:0] wr_arrival,
	input  wire logic [VAL_W-1:0] wr_burst,
	input  wire logic [VAL_W-1:0] wr_prio,
	input  wire logic [VAL_W-1:0] wr_rem,
	input  wire logic [SW-1:0]    rd_addr,
	output logic [PID_W-1:0]      rd_pid,
	output logic [VAL_W-1:0]      rd_arrival,
	output logic [VAL_W-1:0]      rd_burst,
	output logic [VAL_W-1:0]      rd_prio,
	output logic [VAL_W-1:0]      rd_rem
);

	logic [PID_W-1:0] pid_mem [MAX_SLOTS];
	logic [VAL_W-1:0] arr_mem [MAX_SLOTS];
	logic [VAL_W-1:0] burst_mem [MAX_SLOTS];
	logic [VAL_W-1:0] prio_mem [MAX_SLOTS];
	logic [VAL_W-1:0] rem_mem [MAX_SLOTS];

	// Remaining work reads as zero until a slot is loaded
	logic [MAX_SLOTS-1:0] vld_q;
	logic vld_s1;
	logic [VAL_W-1:0] rem_s1;

	// Table writes
	always_ff @(posedge clk) begin
		if (ctrl.load_we) begin
			pid_mem[wr_addr] <= wr_pid;
			arr_mem[wr_addr] <= wr_arrival;
			burst_mem[wr_addr] <= wr_burst;
			prio_mem[wr_addr] <= wr_prio;
		end
		if (ctrl.rem_we) begin
			rem_mem[wr_addr] <= wr_rem;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_pid <= pid_mem[rd_addr];
			rd_arrival <= arr_mem[rd_addr];
			rd_burst <= burst_mem[rd_addr];
			rd_prio <= prio_mem[rd_addr];
			rem_s1 <= rem_mem[rd_addr];
		end
	end

	// Valid bits, cleared at once by reset or a clear beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (ctrl.clear_all) begin
				vld_q <= '0;
			end else if (ctrl.rem_we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_rem = vld_s1 ? rem_s1 : '0;

endmodule

`default_nettype wire

### hw/rtl/pps_scan_unit.sv
// Compare-and-select unit: takes one slot per cycle and keeps the best
// eligible slot and a count of slots with work left; depends on pps_pkg.
`default_nettype none

module pps_scan_unit import pps_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int TIME_WIDTH = TIME_W_DEF,
	localparam int SW = $clog2(MAX_SLOTS),
	localparam int NW = $clog2(MAX_SLOTS + 1),
	localparam int CW = (TIME_WIDTH > VAL_W) ? TIME_WIDTH : VAL_W
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  in_valid,
	input  wire logic [SW-1:0]         in_idx,
	input  wire logic [PID_W-1:0]      in_pid,
	input  wire logic [VAL_W-1:0]      in_arrival,
	input  wire logic [VAL_W-1:0]      in_burst,
	input  wire logic [VAL_W-1:0]      in_prio,
	input  wire logic [VAL_W-1:0]      in_rem,
	input  wire logic [TIME_WIDTH-1:0] now,
	output scan_best_t                 best,
	output logic [SW-1:0]              best_idx,
	output logic [NW-1:0]              nz_cnt
);

	logic found_q;
	logic [NW-1:0] nz_q;
	logic [SW-1:0] idx_q;
	logic [PID_W-1:0] pid_q;
	logic [VAL_W-1:0] arr_q;
	logic [VAL_W-1:0] burst_q;
	logic [VAL_W-1:0] prio_q;
	logic [VAL_W-1:0] rem_q;
	logic has_work;
	logic eligible;
	logic take;

	// Arrived with work left; strict less-than keeps ties on the lower slot
	assign has_work = (in_rem != '0);
	assign eligible = (CW'(in_arrival) <= CW'(now)) && has_work;
	assign take = in_valid && eligible && (!found_q || (in_prio < prio_q));

	// Control: found flag and nonzero count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			nz_q <= '0;
		end else if (start) begin
			found_q <= 1'b0;
			nz_q <= '0;
		end else if (in_valid) begin
			if (take) begin
				found_q <= 1'b1;
			end
			if (has_work) begin
				nz_q <= nz_q + NW'(1);
			end
		end
	end

	// Winner payload
	always_ff @(posedge clk) begin
		if (take) begin
			idx_q <= in_idx;
			pid_q <= in_pid;
			arr_q <= in_arrival;
			burst_q <= in_burst;
			prio_q <= in_prio;
			rem_q <= in_rem;
		end
	end

	assign best.found = found_q;
	assign best.pid = pid_q;
	assign best.arrival = arr_q;
	assign best.burst = burst_q;
	assign best.rem = rem_q;
	assign best_idx = idx_q;
	assign nz_cnt = nz_q;

endmodule

`default_nettype wire

### hw/rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler, top level: sequencer, time counter and
// output register; depends on pps_pkg, pps_slot_mem and pps_scan_unit.
//
// Each input beat (load, tick or clear) yields one output beat. Once a beat
// is accepted the sequencer steps through apply, scan, drain, update and
// emit, skipping scan and drain when the number of counted slots
// (process_count, capped at MAX_SLOTS) is zero: the scan reads one slot per
// cycle through the slot table's single read port and feeds it to one
// compare-and-select unit. s_tready is high only while the sequencer is
// idle; a finished result may still wait in the output register while the
// next beat is accepted, and a result that cannot leave holds the sequencer
// until the output register frees up. Config writes are taken in any cycle
// and are meant to happen only while the block is idle.
`default_nettype none

module preemptive_priority_scheduler import pps_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int TIME_WIDTH = TIME_W_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// process_count
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CNT_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// slot[3:0], proc_id[11:4], arrival[27:12], burst[43:28], prio[59:44]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  wire logic [S_TUSER_W-1:0] s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// running_pid[7:0], tick_start[23:8], completion_time[39:24],
	// turnaround[55:40], waiting[71:56]
	output logic [M_TDATA_W-1:0]      m_tdata,
	// finished[0], all_done[1]
	output logic [M_TUSER_W-1:0]      m_tuser
);

	localparam int SW = $clog2(MAX_SLOTS);
	localparam int NW = $clog2(MAX_SLOTS + 1);
	localparam int CW = (TIME_WIDTH > VAL_W) ? TIME_WIDTH : VAL_W;

	state_t state_q, state_d;

	logic [CNT_W-1:0] pcount_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [TIME_WIDTH-1:0] now_inc;

	// Latched input beat
	logic [CMD_W-1:0] cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PID_W-1:0] pid_q;
	logic [VAL_W-1:0] arr_q;
	logic [VAL_W-1:0] burst_q;
	logic [VAL_W-1:0] prio_q;

	// Scan bookkeeping
	logic [NW-1:0] n_q;
	logic [NW-1:0] idx_q;
	logic scan_vld_s1;
	logic [SW-1:0] idx_s1;
	logic scan_start;
	logic slot_ok;
	logic s_accept;

	// Result staging
	logic [PID_W-1:0] res_pid_q;
	logic [VAL_W-1:0] res_start_q;
	logic res_fin_q;
	logic [VAL_W-1:0] res_ct_q;
	logic [CW-1:0] tat_q;
	logic res_done_q;
	logic [CW-1:0] wt;
	logic fin_now;
	logic out_load;

	// Output register
	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	// Table and scan unit signals
	mem_ctrl_t mem_ctrl;
	logic [SW-1:0] wr_addr;
	logic [VAL_W-1:0] wr_rem;
	logic [PID_W-1:0] rd_pid;
	logic [VAL_W-1:0] rd_arrival;
	logic [VAL_W-1:0] rd_burst;
	logic [VAL_W-1:0] rd_prio;
	logic [VAL_W-1:0] rd_rem;
	scan_best_t best;
	logic [SW-1:0] best_idx;
	logic [NW-1:0] nz_cnt;

	assign cfg_ready = 1'b1;
	assign s_accept = s_tvalid && s_tready;
	assign slot_ok = (int'(slot_q) < MAX_SLOTS);
	assign now_inc = (now_q == '1) ? now_q : now_q + TIME_WIDTH'(1);
	assign fin_now = best.found && (best.rem == VAL_W'(1));
	assign out_load = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	// Waiting time, zero unless the beat finishes a process, and held at zero if saturated time makes it negative
	always_comb begin
		wt = '0;
		if (res_fin_q && (tat_q >= CW'(best.burst))) begin
			wt = tat_q - CW'(best.burst);
		end
	end

	pps_slot_mem #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mem_ctrl),
		.wr_addr   (wr_addr),
		.wr_pid    (pid_q),
		.wr_arrival(arr_q),
		.wr_burst  (burst_q),
		.wr_prio   (prio_q),
		.wr_rem    (wr_rem),
		.rd_addr   (idx_q[SW-1:0]),
		.rd_pid    (rd_pid),
		.rd_arrival(rd_arrival),
		.rd_burst  (rd_burst),
		.rd_prio   (rd_prio),
		.rd_rem    (rd_rem)
	);

	pps_scan_unit #(
		.MAX_SLOTS (MAX_SLOTS),
		.TIME_WIDTH(TIME_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.in_valid  (scan_vld_s1),
		.in_idx    (idx_s1),
		.in_pid    (rd_pid),
		.in_arrival(rd_arrival),
		.in_burst  (rd_burst),
		.in_prio   (rd_prio),
		.in_rem    (rd_rem),
		.now       (now_q),
		.best      (best),
		.best_idx  (best_idx),
		.nz_cnt    (nz_cnt)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and table control
	always_comb begin
		state_d = state_q;
		mem_ctrl = '0;
		s_tready = 1'b0;
		scan_start = 1'b0;
		wr_addr = best_idx;
		wr_rem = best.rem - VAL_W'(1);
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				wr_addr = SW'(slot_q);
				wr_rem = burst_q;
				if (cmd_q == CMD_LOAD && slot_ok) begin
					mem_ctrl.load_we = 1'b1;
					mem_ctrl.rem_we = 1'b1;
				end
				if (cmd_q == CMD_CLEAR) begin
					mem_ctrl.clear_all = 1'b1;
				end
				scan_start = 1'b1;
				state_d = (n_q == '0) ? ST_UPDATE : ST_SCAN;
			end
			ST_SCAN: begin
				mem_ctrl.rd_en = 1'b1;
				if (idx_q == n_q - NW'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (cmd_q == CMD_TICK && best.found) begin
					mem_ctrl.rem_we = 1'b1;
				end
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: config, time, scan index, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= '0;
			now_q <= '0;
			idx_q <= '0;
			scan_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pcount_q <= cfg_data;
			end
			if (state_q == ST_APPLY && cmd_q == CMD_CLEAR) begin
				now_q <= '0;
			end else if (state_q == ST_UPDATE && cmd_q == CMD_TICK) begin
				now_q <= now_inc;
			end
			if (state_q == ST_APPLY) begin
				idx_q <= '0;
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + NW'(1);
			end
			scan_vld_s1 <= mem_ctrl.rd_en;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Input beat capture
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q <= s_tuser[1:0];
			slot_q <= s_tdata[3:0];
			pid_q <= s_tdata[11:4];
			arr_q <= s_tdata[27:12];
			burst_q <= s_tdata[43:28];
			prio_q <= s_tdata[59:44];
			n_q <= (int'(pcount_q) > MAX_SLOTS) ? NW'(MAX_SLOTS) : NW'(pcount_q);
		end
		idx_s1 <= idx_q[SW-1:0];
	end

	// Result staging after the scan
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			res_pid_q <= '0;
			res_start_q <= '0;
			res_fin_q <= 1'b0;
			res_ct_q <= '0;
			tat_q <= '0;
			res_done_q <= (nz_cnt == '0);
			if (cmd_q == CMD_TICK) begin
				res_start_q <= VAL_W'(now_q);
				if (best.found) begin
					res_pid_q <= best.pid;
				end
				if (fin_now) begin
					res_fin_q <= 1'b1;
					res_ct_q <= VAL_W'(now_inc);
					tat_q <= CW'(now_inc) - CW'(best.arrival);
					res_done_q <= (nz_cnt == NW'(1));
				end
			end
		end
	end

	// Output register load
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {VAL_W'(wt), VAL_W'(tat_q), res_ct_q, res_start_q, res_pid_q};
			m_tuser_q <= {res_done_q, res_fin_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

`default_nettype wire
